>>> hw/rtl/crcfr_pkg.sv
// Shared types, constants and the CRC-16/MODBUS byte update for the frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package crcfr_pkg;

    localparam int MAX_PAYLOAD_DEF = 32;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // Configuration register indexes
    localparam logic [1:0] CFG_HDR_ONE = 2'd0;
    localparam logic [1:0] CFG_HDR_TWO = 2'd1;
    localparam logic [1:0] CFG_VERSION = 2'd2;
    localparam logic [1:0] CFG_MAX_LEN = 2'd3;

    localparam logic [7:0] HDR_ONE_RST = 8'hAA;
    localparam logic [7:0] HDR_TWO_RST = 8'h55;
    localparam logic [7:0] VERSION_RST = 8'h01;
    localparam logic [5:0] MAX_LEN_RST = 6'd32;

    typedef enum logic [2:0] {
        PH_HDR1,
        PH_HDR2,
        PH_VER,
        PH_LEN,
        PH_SEQ,
        PH_PAY,
        PH_CRCL,
        PH_CRCH
    } phase_t;

    typedef enum logic [1:0] {
        EV_ABSORB = 2'd0,
        EV_ERROR  = 2'd1,
        EV_GOOD   = 2'd2
    } event_t;

    typedef enum logic {
        RO_IDLE,
        RO_EMIT
    } ro_state_t;

    // What one accepted byte produced, handed from parser to emitter
    typedef struct packed {
        event_t     ev;
        logic       receiving;
        logic       burst;
        logic [5:0] len;
        logic [7:0] seq;
    } parse_res_t;

    function automatic logic [15:0] crc16_step(input logic [15:0] crc,
                                               input logic [7:0]  data_byte);
        logic [15:0] c;
        c = crc ^ {8'h00, data_byte};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/crcfr_payload_ram.sv
// Payload buffer: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module crcfr_payload_ram #(
    parameter int DEPTH = crcfr_pkg::MAX_PAYLOAD_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic [7:0]         rd_data
);

    logic [7:0] mem_array [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/crcfr_parser.sv
// Frame parser: header search, field capture, running CRC, counters and config registers.
`timescale 1ns / 1ps
`default_nettype none

module crcfr_parser #(
    parameter int MAX_PAYLOAD = crcfr_pkg::MAX_PAYLOAD_DEF,
    parameter int COUNT_WIDTH = crcfr_pkg::COUNT_WIDTH_DEF,
    parameter int AW          = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write_en,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [7:0]             cfg_data,
    input  wire logic                   beat_fire,
    input  wire logic [7:0]             rx_byte,
    output logic                        wr_en,
    output logic [AW-1:0]               wr_addr,
    output logic [7:0]                  wr_data,
    output crcfr_pkg::parse_res_t       res,
    output logic [COUNT_WIDTH-1:0]      err_count_next,
    output logic [COUNT_WIDTH-1:0]      good_count_next
);

    localparam logic [6:0] MAX_P = 7'(MAX_PAYLOAD);

    logic [7:0] hdr1_reg, hdr2_reg, version_reg;
    logic [5:0] max_len_reg;

    crcfr_pkg::phase_t phase_reg, phase_next;
    logic [5:0]  length_reg, length_next;
    logic [5:0]  fill_reg, fill_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_low_reg, crc_low_next;
    logic [7:0]  seq_reg, seq_next;
    logic [COUNT_WIDTH-1:0] err_reg, err_next;
    logic [COUNT_WIDTH-1:0] good_reg, good_next;

    logic        is_hdr1, is_hdr2, ver_ok, len_ok, crc_ok, pay_done;
    logic        fail_now, good_now;
    logic [6:0]  limit;
    logic [5:0]  fill_inc;
    logic [15:0] crc_in, crc_upd;
    crcfr_pkg::phase_t resync_phase;

    assign is_hdr1  = (rx_byte == hdr1_reg);
    assign is_hdr2  = (rx_byte == hdr2_reg);
    assign ver_ok   = (rx_byte == version_reg);
    assign limit    = (7'(max_len_reg) < MAX_P) ? 7'(max_len_reg) : MAX_P;
    assign len_ok   = (rx_byte <= 8'(limit));
    assign fill_inc = fill_reg + 6'd1;
    assign pay_done = (fill_inc >= length_reg);
    assign crc_ok   = ({rx_byte, crc_low_reg} == crc_reg);
    assign crc_in   = (phase_reg == crcfr_pkg::PH_VER) ? crcfr_pkg::CRC_INIT : crc_reg;
    assign crc_upd  = crcfr_pkg::crc16_step(crc_in, rx_byte);

    assign fail_now = ((phase_reg == crcfr_pkg::PH_VER)  && !ver_ok)
                   || ((phase_reg == crcfr_pkg::PH_LEN)  && !len_ok)
                   || ((phase_reg == crcfr_pkg::PH_CRCH) && !crc_ok);
    assign good_now = (phase_reg == crcfr_pkg::PH_CRCH) && crc_ok;

    // A failing byte that matches header one already starts the next search
    assign resync_phase = is_hdr1 ? crcfr_pkg::PH_HDR2 : crcfr_pkg::PH_HDR1;

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            crcfr_pkg::PH_HDR1:
            begin
                phase_next = is_hdr1 ? crcfr_pkg::PH_HDR2 : crcfr_pkg::PH_HDR1;
            end
            crcfr_pkg::PH_HDR2:
            begin
                if (is_hdr2)
                begin
                    phase_next = crcfr_pkg::PH_VER;
                end
                else
                begin
                    phase_next = is_hdr1 ? crcfr_pkg::PH_HDR2 : crcfr_pkg::PH_HDR1;
                end
            end
            crcfr_pkg::PH_VER:
            begin
                phase_next = ver_ok ? crcfr_pkg::PH_LEN : resync_phase;
            end
            crcfr_pkg::PH_LEN:
            begin
                phase_next = len_ok ? crcfr_pkg::PH_SEQ : resync_phase;
            end
            crcfr_pkg::PH_SEQ:
            begin
                phase_next = (length_reg == 6'd0) ? crcfr_pkg::PH_CRCL : crcfr_pkg::PH_PAY;
            end
            crcfr_pkg::PH_PAY:
            begin
                phase_next = pay_done ? crcfr_pkg::PH_CRCL : crcfr_pkg::PH_PAY;
            end
            crcfr_pkg::PH_CRCL:
            begin
                phase_next = crcfr_pkg::PH_CRCH;
            end
            crcfr_pkg::PH_CRCH:
            begin
                phase_next = crc_ok ? crcfr_pkg::PH_HDR1 : resync_phase;
            end
        endcase
    end

    always_comb
    begin
        length_next  = length_reg;
        fill_next    = fill_reg;
        crc_next     = crc_reg;
        crc_low_next = crc_low_reg;
        seq_next     = seq_reg;
        err_next     = err_reg;
        good_next    = good_reg;
        if (fail_now || good_now)
        begin
            length_next  = 6'd0;
            fill_next    = 6'd0;
            crc_next     = crcfr_pkg::CRC_INIT;
            crc_low_next = 8'd0;
            if (fail_now)
            begin
                err_next = err_reg + 1'b1;
            end
            else
            begin
                good_next = good_reg + 1'b1;
            end
        end
        else
        begin
            unique case (phase_reg)
                crcfr_pkg::PH_VER:
                begin
                    crc_next = crc_upd;
                end
                crcfr_pkg::PH_LEN:
                begin
                    length_next = rx_byte[5:0];
                    fill_next   = 6'd0;
                    crc_next    = crc_upd;
                end
                crcfr_pkg::PH_SEQ:
                begin
                    seq_next = rx_byte;
                    crc_next = crc_upd;
                end
                crcfr_pkg::PH_PAY:
                begin
                    fill_next = fill_inc;
                    crc_next  = crc_upd;
                end
                crcfr_pkg::PH_CRCL:
                begin
                    crc_low_next = rx_byte;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign wr_en   = beat_fire && (phase_reg == crcfr_pkg::PH_PAY) && (7'(fill_reg) < MAX_P);
    assign wr_addr = fill_reg[AW-1:0];
    assign wr_data = rx_byte;

    always_comb
    begin
        if (fail_now)
        begin
            res.ev = crcfr_pkg::EV_ERROR;
        end
        else if (good_now)
        begin
            res.ev = crcfr_pkg::EV_GOOD;
        end
        else
        begin
            res.ev = crcfr_pkg::EV_ABSORB;
        end
        res.receiving = (phase_next != crcfr_pkg::PH_HDR1);
        res.burst     = good_now && (length_reg != 6'd0);
        res.len       = good_now ? length_reg : 6'd0;
        res.seq       = good_now ? seq_reg : 8'd0;
    end

    assign err_count_next  = err_next;
    assign good_count_next = good_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr1_reg    <= crcfr_pkg::HDR_ONE_RST;
            hdr2_reg    <= crcfr_pkg::HDR_TWO_RST;
            version_reg <= crcfr_pkg::VERSION_RST;
            max_len_reg <= crcfr_pkg::MAX_LEN_RST;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                crcfr_pkg::CFG_HDR_ONE: hdr1_reg    <= cfg_data;
                crcfr_pkg::CFG_HDR_TWO: hdr2_reg    <= cfg_data;
                crcfr_pkg::CFG_VERSION: version_reg <= cfg_data;
                crcfr_pkg::CFG_MAX_LEN: max_len_reg <= cfg_data[5:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= crcfr_pkg::PH_HDR1;
            length_reg  <= 6'd0;
            fill_reg    <= 6'd0;
            crc_reg     <= crcfr_pkg::CRC_INIT;
            crc_low_reg <= 8'd0;
            seq_reg     <= 8'd0;
            err_reg     <= '0;
            good_reg    <= '0;
        end
        else if (beat_fire)
        begin
            phase_reg   <= phase_next;
            length_reg  <= length_next;
            fill_reg    <= fill_next;
            crc_reg     <= crc_next;
            crc_low_reg <= crc_low_next;
            seq_reg     <= seq_next;
            err_reg     <= err_next;
            good_reg    <= good_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/crcfr_emitter.sv
// Result register and payload readout sequencer driving the output channel.
`timescale 1ns / 1ps
`default_nettype none

module crcfr_emitter #(
    parameter int MAX_PAYLOAD = crcfr_pkg::MAX_PAYLOAD_DEF,
    parameter int COUNT_WIDTH = crcfr_pkg::COUNT_WIDTH_DEF,
    parameter int AW          = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   beat_fire,
    input  wire crcfr_pkg::parse_res_t  res,
    input  wire logic [COUNT_WIDTH-1:0] err_count,
    input  wire logic [COUNT_WIDTH-1:0] good_count,
    input  wire logic                   out_ready,
    input  wire logic [7:0]             rd_data,
    output logic                        accept_ok,
    output logic                        rd_en,
    output logic [AW-1:0]               rd_addr,
    output logic                        out_valid,
    output logic [1:0]                  event_res,
    output logic                        receiving,
    output logic [31:0]                 errors_seen,
    output logic [31:0]                 frames_seen,
    output logic [7:0]                  frame_sequence,
    output logic [5:0]                  frame_length,
    output logic [4:0]                  byte_position,
    output logic [7:0]                  payload_value,
    output logic                        has_value,
    output logic                        last
);

    crcfr_pkg::ro_state_t ro_state_reg, ro_state_next;
    logic [5:0]  idx_reg, idx_next;
    logic        out_valid_reg, out_valid_next;
    crcfr_pkg::event_t ev_reg, ev_next;
    logic        recv_reg, recv_next;
    logic [COUNT_WIDTH-1:0] err_reg, err_next;
    logic [COUNT_WIDTH-1:0] good_reg, good_next;
    logic [7:0]  seq_reg, seq_next;
    logic [5:0]  len_reg, len_next;
    logic [4:0]  pos_reg, pos_next;
    logic [7:0]  val_reg, val_next;
    logic        has_reg, has_next;
    logic        last_reg, last_next;

    logic       slot_free, burst_last;
    logic [5:0] idx_inc;

    assign slot_free  = !out_valid_reg || out_ready;
    assign accept_ok  = (ro_state_reg == crcfr_pkg::RO_IDLE) && slot_free;
    assign idx_inc    = idx_reg + 6'd1;
    assign burst_last = (idx_inc == len_reg);

    always_comb
    begin
        ro_state_next = ro_state_reg;
        unique case (ro_state_reg)
            crcfr_pkg::RO_IDLE:
            begin
                if (beat_fire && res.burst)
                begin
                    ro_state_next = crcfr_pkg::RO_EMIT;
                end
            end
            crcfr_pkg::RO_EMIT:
            begin
                if (slot_free && burst_last)
                begin
                    ro_state_next = crcfr_pkg::RO_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        idx_next  = idx_reg;
        ev_next   = ev_reg;
        recv_next = recv_reg;
        err_next  = err_reg;
        good_next = good_reg;
        seq_next  = seq_reg;
        len_next  = len_reg;
        pos_next  = pos_reg;
        val_next  = val_reg;
        has_next  = has_reg;
        last_next = last_reg;
        rd_en     = 1'b0;
        rd_addr   = '0;
        unique case (ro_state_reg)
            crcfr_pkg::RO_IDLE:
            begin
                if (beat_fire)
                begin
                    ev_next   = res.ev;
                    recv_next = res.receiving;
                    err_next  = err_count;
                    good_next = good_count;
                    seq_next  = res.seq;
                    len_next  = res.len;
                    idx_next  = 6'd0;
                    if (res.burst)
                    begin
                        // fetch the first payload byte, items follow from the buffer
                        rd_en = 1'b1;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        pos_next  = 5'd0;
                        val_next  = 8'd0;
                        has_next  = 1'b0;
                        last_next = 1'b1;
                    end
                end
            end
            crcfr_pkg::RO_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    pos_next  = idx_reg[4:0];
                    val_next  = rd_data;
                    has_next  = 1'b1;
                    last_next = burst_last;
                    if (!burst_last)
                    begin
                        // prefetch the next byte while this one goes out
                        rd_en    = 1'b1;
                        rd_addr  = idx_inc[AW-1:0];
                        idx_next = idx_inc;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ro_state_reg  <= crcfr_pkg::RO_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= 6'd0;
        end
        else
        begin
            ro_state_reg  <= ro_state_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ev_reg   <= ev_next;
        recv_reg <= recv_next;
        err_reg  <= err_next;
        good_reg <= good_next;
        seq_reg  <= seq_next;
        len_reg  <= len_next;
        pos_reg  <= pos_next;
        val_reg  <= val_next;
        has_reg  <= has_next;
        last_reg <= last_next;
    end

    assign out_valid      = out_valid_reg;
    assign event_res      = ev_reg;
    assign receiving      = recv_reg;
    assign errors_seen    = 32'(err_reg);
    assign frames_seen    = 32'(good_reg);
    assign frame_sequence = seq_reg;
    assign frame_length   = len_reg;
    assign byte_position  = pos_reg;
    assign payload_value  = val_reg;
    assign has_value      = has_reg;
    assign last           = last_reg;

endmodule

`default_nettype wire

>>> hw/rtl/crc_checked_frame_receiver.sv
// A byte's status result is valid the cycle after the byte is accepted. A good frame
// with payload gives its first item via the buffer read and output registers, then one
// item per cycle from the buffer while the sink is ready; input is held off until the
// last item is taken. Throughput: one byte per cycle otherwise, paced by the output
// register handshake. Reset: phase, counters, CRC and config return to defaults at
// once; the payload buffer is not cleared and is read back only once filled by a frame.
`timescale 1ns / 1ps
`default_nettype none

module crc_checked_frame_receiver #(
    parameter int MAX_PAYLOAD = crcfr_pkg::MAX_PAYLOAD_DEF,
    parameter int COUNT_WIDTH = crcfr_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       event_res,
    output logic             receiving,
    output logic [31:0]      errors_seen,
    output logic [31:0]      frames_seen,
    output logic [7:0]       frame_sequence,
    output logic [5:0]       frame_length,
    output logic [4:0]       byte_position,
    output logic [7:0]       payload_value,
    output logic             has_value,
    output logic             last
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic                   beat_fire;
    logic                   wr_en, rd_en;
    logic [AW-1:0]          wr_addr, rd_addr;
    logic [7:0]             wr_data, rd_data;
    crcfr_pkg::parse_res_t  res;
    logic [COUNT_WIDTH-1:0] err_count, good_count;

    assign beat_fire = in_valid && in_ready;

    crcfr_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .COUNT_WIDTH (COUNT_WIDTH),
        .AW          (AW)
    ) u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .beat_fire       (beat_fire),
        .rx_byte         (rx_byte),
        .wr_en           (wr_en),
        .wr_addr         (wr_addr),
        .wr_data         (wr_data),
        .res             (res),
        .err_count_next  (err_count),
        .good_count_next (good_count)
    );

    crcfr_payload_ram #(
        .DEPTH (MAX_PAYLOAD),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    crcfr_emitter #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .COUNT_WIDTH (COUNT_WIDTH),
        .AW          (AW)
    ) u_emitter (
        .clk            (clk),
        .rst_n          (rst_n),
        .beat_fire      (beat_fire),
        .res            (res),
        .err_count      (err_count),
        .good_count     (good_count),
        .out_ready      (out_ready),
        .rd_data        (rd_data),
        .accept_ok      (in_ready),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr),
        .out_valid      (out_valid),
        .event_res      (event_res),
        .receiving      (receiving),
        .errors_seen    (errors_seen),
        .frames_seen    (frames_seen),
        .frame_sequence (frame_sequence),
        .frame_length   (frame_length),
        .byte_position  (byte_position),
        .payload_value  (payload_value),
        .has_value      (has_value),
        .last           (last)
    );

`ifndef SYNTH
    // A taken payload beat that is not the last is followed at once by the next one
    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && has_value && !last) |=>
        (out_valid && has_value && event_res == crcfr_pkg::EV_GOOD))
        else $error("payload burst stalled or broke off");

    a_burst_position: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && has_value && !last) |=>
        (byte_position == 5'($past(byte_position) + 5'd1)))
        else $error("payload position did not advance by one");

    a_no_input_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && has_value && !last) |-> !in_ready)
        else $error("input taken while a payload burst is pending");

    a_write_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (beat_fire && !rd_en))
        else $error("payload buffer written outside an accepted beat");
`endif

endmodule

`default_nettype wire

>>> verif/crc_checked_frame_receiver_tb.sv
// Self-checking testbench for the CRC-16/MODBUS framed byte receiver.
`timescale 1ns / 1ps

module crc_checked_frame_receiver_tb;

    import crcfr_pkg::*;

    typedef struct packed {
        logic [1:0]  ev;
        logic        receiving;
        logic [31:0] errs;
        logic [31:0] frames;
        logic [7:0]  seq;
        logic [5:0]  len;
        logic [4:0]  pos;
        logic [7:0]  val;
        logic        has;
        logic        last;
    } frame_beat_t;

    // Where a directed byte comes from: literal, or derived from the running CRC
    typedef enum logic [1:0] {
        SRC_LIT,
        SRC_CRC_LO,
        SRC_CRC_HI,
        SRC_CRC_BAD
    } byte_src_t;

    typedef struct packed {
        byte_src_t   src;
        logic [7:0]  lit;
        logic        typed;
        logic [1:0]  ev;
        logic        rcv;
        logic [31:0] errs;
    } opening_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write_en = 1'b0;
    logic [1:0]  cfg_index = CFG_HDR_ONE;
    logic [7:0]  cfg_data = 8'h00;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  event_res;
    logic        receiving;
    logic [31:0] errors_seen;
    logic [31:0] frames_seen;
    logic [7:0]  frame_sequence;
    logic [5:0]  frame_length;
    logic [4:0]  byte_position;
    logic [7:0]  payload_value;
    logic        has_value;
    logic        last;

    // Parser model state and its copy of the registers
    logic [7:0]  cfg_hdr1;
    logic [7:0]  cfg_hdr2;
    logic [7:0]  cfg_ver;
    logic [5:0]  cfg_maxlen;
    phase_t      rx_phase;
    logic [5:0]  held_len;
    logic [5:0]  fill_cnt;
    logic [15:0] crc_acc;
    logic [7:0]  crc_lo_byte;
    logic [7:0]  held_seq;
    logic [7:0]  payload_mem [0:31];
    logic [31:0] err_cnt;
    logic [31:0] good_cnt;

    frame_beat_t  pending_beats [$];
    opening_row_t opening_rows [$];
    int           beats_mismatched = 0;
    int           bytes_offered = 0;
    bit           tx_steady = 1'b0;
    bit           rx_steady = 1'b0;
    int           rx_hold_len = 0;

    crc_checked_frame_receiver uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .event_res      (event_res),
        .receiving      (receiving),
        .errors_seen    (errors_seen),
        .frames_seen    (frames_seen),
        .frame_sequence (frame_sequence),
        .frame_length   (frame_length),
        .byte_position  (byte_position),
        .payload_value  (payload_value),
        .has_value      (has_value),
        .last           (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [15:0] crc_update(input logic [15:0] acc, input logic [7:0] d);
        logic [15:0] c;
        logic        lsb;
        c = acc ^ {8'h00, d};
        repeat (8)
        begin
            lsb = c[0];
            c = c >> 1;
            if (lsb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    function automatic frame_beat_t make_beat(input logic [1:0] ev, input logic [7:0] seq,
                                              input logic [5:0] len, input logic [4:0] pos,
                                              input logic [7:0] val, input logic has,
                                              input logic lst);
        frame_beat_t r;
        r.ev        = ev;
        r.receiving = (rx_phase != PH_HDR1);
        r.errs      = err_cnt;
        r.frames    = good_cnt;
        r.seq       = seq;
        r.len       = len;
        r.pos       = pos;
        r.val       = val;
        r.has       = has;
        r.last      = lst;
        return r;
    endfunction

    function automatic void restart_parser();
        rx_phase    = PH_HDR1;
        held_len    = 6'd0;
        fill_cnt    = 6'd0;
        crc_acc     = CRC_INIT;
        crc_lo_byte = 8'h00;
    endfunction

    function automatic void count_error(input logic [7:0] b);
        err_cnt = err_cnt + 32'd1;
        restart_parser();
        // a failing byte that matches header one already starts the next frame
        if (b == cfg_hdr1)
            rx_phase = PH_HDR2;
    endfunction

    // Advance the parser model by one byte and queue the beats it produces
    function automatic void predict_byte(input logic [7:0] b);
        logic [1:0] ev;
        logic [5:0] lim;
        logic [5:0] n;
        logic [7:0] seq;
        ev  = EV_ABSORB;
        lim = (cfg_maxlen < 6'd32) ? cfg_maxlen : 6'd32;
        case (rx_phase)
            PH_HDR1:
            begin
                if (b == cfg_hdr1)
                    rx_phase = PH_HDR2;
            end
            PH_HDR2:
            begin
                if (b == cfg_hdr2)
                    rx_phase = PH_VER;
                else if (b != cfg_hdr1)
                    rx_phase = PH_HDR1;
            end
            PH_VER:
            begin
                if (b != cfg_ver)
                begin
                    count_error(b);
                    ev = EV_ERROR;
                end
                else
                begin
                    crc_acc  = crc_update(CRC_INIT, b);
                    rx_phase = PH_LEN;
                end
            end
            PH_LEN:
            begin
                if (b > {2'b00, lim})
                begin
                    count_error(b);
                    ev = EV_ERROR;
                end
                else
                begin
                    held_len = b[5:0];
                    fill_cnt = 6'd0;
                    crc_acc  = crc_update(crc_acc, b);
                    rx_phase = PH_SEQ;
                end
            end
            PH_SEQ:
            begin
                held_seq = b;
                crc_acc  = crc_update(crc_acc, b);
                rx_phase = (held_len == 6'd0) ? PH_CRCL : PH_PAY;
            end
            PH_PAY:
            begin
                if (fill_cnt < 6'd32)
                    payload_mem[fill_cnt[4:0]] = b;
                fill_cnt = fill_cnt + 6'd1;
                crc_acc  = crc_update(crc_acc, b);
                if (fill_cnt >= held_len)
                    rx_phase = PH_CRCL;
            end
            PH_CRCL:
            begin
                crc_lo_byte = b;
                rx_phase    = PH_CRCH;
            end
            default:
            begin
                if ({b, crc_lo_byte} == crc_acc)
                begin
                    n   = held_len;
                    seq = held_seq;
                    good_cnt = good_cnt + 32'd1;
                    restart_parser();
                    if (n == 6'd0)
                        pending_beats.push_back(make_beat(EV_GOOD, seq, 6'd0, 5'd0, 8'h00,
                                                          1'b0, 1'b1));
                    for (int i = 0; i < n; i++)
                        pending_beats.push_back(make_beat(EV_GOOD, seq, n, 5'(i),
                                                          payload_mem[i], 1'b1,
                                                          (i + 1 == n)));
                    return;
                end
                count_error(b);
                ev = EV_ERROR;
            end
        endcase
        pending_beats.push_back(make_beat(ev, 8'h00, 6'd0, 5'd0, 8'h00, 1'b0, 1'b1));
    endfunction

    // Offer one byte and hold it until the beat is taken
    task automatic drive_byte(input logic [7:0] b);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 13);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        bytes_offered++;
    endtask

    task automatic offer_byte(input logic [7:0] b);
        predict_byte(b);
        drive_byte(b);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_beats.size() != 0);
    endtask

    task automatic set_config(input logic [7:0] h1, input logic [7:0] h2,
                              input logic [7:0] ver, input logic [7:0] maxl);
        logic [7:0] vals [0:3];
        vals[CFG_HDR_ONE] = h1;
        vals[CFG_HDR_TWO] = h2;
        vals[CFG_VERSION] = ver;
        vals[CFG_MAX_LEN] = maxl;
        drain_results();
        repeat (4) @(posedge clk);
        for (int i = 0; i < 4; i++)
        begin
            cfg_write_en <= 1'b1;
            cfg_index    <= 2'(i);
            cfg_data     <= vals[i];
            @(posedge clk);
        end
        cfg_write_en <= 1'b0;
        cfg_hdr1   = h1;
        cfg_hdr2   = h2;
        cfg_ver    = ver;
        cfg_maxlen = maxl[5:0];
    endtask

    // Mostly well-formed frames with random content; some are broken on purpose
    task automatic send_frame();
        int         kind;
        int         n;
        logic [5:0] lim;
        logic [7:0] v;
        lim  = (cfg_maxlen < 6'd32) ? cfg_maxlen : 6'd32;
        kind = $urandom_range(0, 19);
        offer_byte(cfg_hdr1);
        if (kind == 0)
            offer_byte(cfg_hdr1);
        offer_byte(cfg_hdr2);
        if (kind == 1 || kind == 2)
        begin
            if (kind == 2 && cfg_hdr1 != cfg_ver)
                v = cfg_hdr1;
            else
                v = cfg_ver ^ 8'($urandom_range(1, 255));
            offer_byte(v);
            return;
        end
        offer_byte(cfg_ver);
        if (kind == 3)
        begin
            offer_byte(8'($urandom_range(lim + 1, 255)));
            return;
        end
        n = (kind == 4) ? lim : $urandom_range(0, (lim < 6) ? lim : 6);
        offer_byte(8'(n));
        offer_byte(8'($urandom));
        repeat (n)
            offer_byte((kind == 5) ? 8'hFF : 8'($urandom));
        if (kind == 6)
            offer_byte(crc_acc[7:0] ^ 8'($urandom_range(1, 255)));
        else
            offer_byte(crc_acc[7:0]);
        if (kind == 7)
            offer_byte(crc_acc[15:8] ^ 8'h80);
        else if (kind == 8)
            offer_byte(cfg_hdr1);
        else
            offer_byte(crc_acc[15:8]);
    endtask

    task automatic run_random(input int count);
        int         target;
        logic [7:0] v;
        target = bytes_offered + count;
        while (bytes_offered < target)
        begin
            if ($urandom_range(0, 9) == 0)
                tx_steady = !tx_steady;
            if ($urandom_range(0, 9) < 7)
                send_frame();
            else
            begin
                repeat ($urandom_range(1, 3))
                begin
                    case ($urandom_range(0, 5))
                        0:       v = 8'h00;
                        1:       v = 8'hFF;
                        2:       v = cfg_hdr1;
                        default: v = 8'($urandom);
                    endcase
                    offer_byte(v);
                end
            end
        end
    endtask

    function automatic opening_row_t mk_row(input byte_src_t src, input logic [7:0] lit,
                                            input logic typed, input logic [1:0] ev,
                                            input logic rcv, input logic [31:0] errs);
        opening_row_t r;
        r.src   = src;
        r.lit   = lit;
        r.typed = typed;
        r.ev    = ev;
        r.rcv   = rcv;
        r.errs  = errs;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            beats_mismatched++;
            $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : beat_check
        frame_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_beats.size() == 0)
            begin
                beats_mismatched++;
                $display("%0t: unexpected beat, expected none, actual event %0d",
                         $time, event_res);
            end
            else
            begin
                want = pending_beats.pop_front();
                check_field("event_res", want.ev, event_res);
                check_field("receiving", want.receiving, receiving);
                check_field("errors_seen", want.errs, errors_seen);
                check_field("frames_seen", want.frames, frames_seen);
                check_field("frame_sequence", want.seq, frame_sequence);
                check_field("frame_length", want.len, frame_length);
                check_field("byte_position", want.pos, byte_position);
                check_field("payload_value", want.val, payload_value);
                check_field("has_value", want.has, has_value);
                check_field("last", want.last, last);
            end
        end
    end

    // Result sink: stall a random number of cycles before each beat
    initial
    begin
        int stall;
        wait (rst_n);
        forever
        begin
            if ($urandom_range(0, 19) == 0)
                rx_steady = !rx_steady;
            if (rx_hold_len != 0)
            begin
                stall = rx_hold_len;
                rx_hold_len = 0;
            end
            else
                stall = rx_steady ? 0 : $urandom_range(0, 13);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
        end
    end

    initial
    begin
        #(4 * 400000);
        $display("crc_checked_frame_receiver_tb failed");
        $finish;
    end

    initial
    begin
        opening_row_t row;
        frame_beat_t  beat;
        logic [7:0]   b;

        cfg_hdr1   = HDR_ONE_RST;
        cfg_hdr2   = HDR_TWO_RST;
        cfg_ver    = VERSION_RST;
        cfg_maxlen = MAX_LEN_RST;
        restart_parser();
        held_seq = 8'h00;
        err_cnt  = 32'd0;
        good_cnt = 32'd0;

        // noise, repeated header one, bad version, header-one version, oversize length
        opening_rows.push_back(mk_row(SRC_LIT, 8'h00, 1'b1, EV_ABSORB, 1'b0, 32'd0));
        opening_rows.push_back(mk_row(SRC_LIT, 8'hFF, 1'b1, EV_ABSORB, 1'b0, 32'd0));
        opening_rows.push_back(mk_row(SRC_LIT, 8'hAA, 1'b1, EV_ABSORB, 1'b1, 32'd0));
        opening_rows.push_back(mk_row(SRC_LIT, 8'hAA, 1'b1, EV_ABSORB, 1'b1, 32'd0));
        opening_rows.push_back(mk_row(SRC_LIT, 8'h55, 1'b1, EV_ABSORB, 1'b1, 32'd0));
        opening_rows.push_back(mk_row(SRC_LIT, 8'h02, 1'b1, EV_ERROR, 1'b0, 32'd1));
        opening_rows.push_back(mk_row(SRC_LIT, 8'hAA, 1'b1, EV_ABSORB, 1'b1, 32'd1));
        opening_rows.push_back(mk_row(SRC_LIT, 8'h55, 1'b1, EV_ABSORB, 1'b1, 32'd1));
        opening_rows.push_back(mk_row(SRC_LIT, 8'hAA, 1'b1, EV_ERROR, 1'b1, 32'd2));
        opening_rows.push_back(mk_row(SRC_LIT, 8'h55, 1'b1, EV_ABSORB, 1'b1, 32'd2));
        opening_rows.push_back(mk_row(SRC_LIT, 8'h01, 1'b1, EV_ABSORB, 1'b1, 32'd2));
        opening_rows.push_back(mk_row(SRC_LIT, 8'h21, 1'b1, EV_ERROR, 1'b0, 32'd3));
        // empty good frame
        opening_rows.push_back(mk_row(SRC_LIT, 8'hAA, 1'b1, EV_ABSORB, 1'b1, 32'd3));
        opening_rows.push_back(mk_row(SRC_LIT, 8'h55, 1'b1, EV_ABSORB, 1'b1, 32'd3));
        opening_rows.push_back(mk_row(SRC_LIT, 8'h01, 1'b1, EV_ABSORB, 1'b1, 32'd3));
        opening_rows.push_back(mk_row(SRC_LIT, 8'h00, 1'b1, EV_ABSORB, 1'b1, 32'd3));
        opening_rows.push_back(mk_row(SRC_LIT, 8'h7E, 1'b1, EV_ABSORB, 1'b1, 32'd3));
        opening_rows.push_back(mk_row(SRC_CRC_LO, 8'h00, 1'b0, EV_ABSORB, 1'b0, 32'd0));
        opening_rows.push_back(mk_row(SRC_CRC_HI, 8'h00, 1'b0, EV_ABSORB, 1'b0, 32'd0));
        // one-byte frame with a corrupted CRC high byte
        opening_rows.push_back(mk_row(SRC_LIT, 8'hAA, 1'b0, EV_ABSORB, 1'b0, 32'd0));
        opening_rows.push_back(mk_row(SRC_LIT, 8'h55, 1'b0, EV_ABSORB, 1'b0, 32'd0));
        opening_rows.push_back(mk_row(SRC_LIT, 8'h01, 1'b0, EV_ABSORB, 1'b0, 32'd0));
        opening_rows.push_back(mk_row(SRC_LIT, 8'h01, 1'b0, EV_ABSORB, 1'b0, 32'd0));
        opening_rows.push_back(mk_row(SRC_LIT, 8'h81, 1'b0, EV_ABSORB, 1'b0, 32'd0));
        opening_rows.push_back(mk_row(SRC_LIT, 8'hFF, 1'b0, EV_ABSORB, 1'b0, 32'd0));
        opening_rows.push_back(mk_row(SRC_CRC_LO, 8'h00, 1'b0, EV_ABSORB, 1'b0, 32'd0));
        opening_rows.push_back(mk_row(SRC_CRC_BAD, 8'h00, 1'b0, EV_ABSORB, 1'b0, 32'd0));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_rows[i])
        begin
            row = opening_rows[i];
            case (row.src)
                SRC_CRC_LO:  b = crc_acc[7:0];
                SRC_CRC_HI:  b = crc_acc[15:8];
                SRC_CRC_BAD: b = crc_acc[15:8] ^ 8'h01;
                default:     b = row.lit;
            endcase
            predict_byte(b);
            if (row.typed)
            begin
                void'(pending_beats.pop_back());
                beat           = '0;
                beat.ev        = row.ev;
                beat.receiving = row.rcv;
                beat.errs      = row.errs;
                beat.last      = 1'b1;
                pending_beats.push_back(beat);
            end
            drive_byte(b);
        end

        run_random(80);

        // zero length limit: only empty frames pass
        set_config(8'h00, 8'hFF, 8'hFF, 8'd0);
        run_random(40);

        // equal header bytes, length limit saturates
        set_config(8'h3C, 8'h3C, 8'h00, 8'd63);
        run_random(40);
        drain_results();
        run_random(40);

        set_config(8'hFF, 8'h00, 8'h80, 8'd5);
        run_random(50);

        // back to defaults; stall the sink for a long stretch while bytes keep coming
        set_config(HDR_ONE_RST, HDR_TWO_RST, VERSION_RST, {2'b00, MAX_LEN_RST});
        tx_steady   = 1'b1;
        rx_hold_len = 300;
        run_random(60);
        tx_steady = 1'b0;

        drain_results();
        repeat (40) @(posedge clk);
        if (beats_mismatched == 0)
            $display("crc_checked_frame_receiver_tb passed");
        else
            $display("crc_checked_frame_receiver_tb failed");
        $finish;
    end

endmodule
